// ===== src/whr_pkg.sv =====
// Shared types, constants and codes for the watchpoint hit resolver.
// No dependencies; whr_decode, whr_cell and the top level refer to it by scoped names.
package whr_pkg;

  // Default slot count of the top level.
  localparam int SLOTS_DEFAULT = 16;

  // Field widths fixed by the item format.
  localparam int ADDR_W   = 64;
  localparam int INSN_W   = 32;
  localparam int IDX_W    = 4;
  localparam int LEN_W    = 4;
  localparam int SIZE_W   = 7;
  localparam int ACTIVE_W = 5;

  // Item actions.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CHECK = 1'b1;

  // Reset value of the scan count.
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

  // SVE loads and stores always move one 16-byte unit.
  localparam logic [SIZE_W-1:0] SVE_BYTES = 7'd16;

  // Opcode field of the SIMD multiple-structure group.
  localparam logic [3:0] OP_FOUR_REG_A  = 4'h0;
  localparam logic [3:0] OP_FOUR_REG_B  = 4'h2;
  localparam logic [3:0] OP_THREE_REG_A = 4'h4;
  localparam logic [3:0] OP_THREE_REG_B = 4'h6;
  localparam logic [3:0] OP_TWO_REG_A   = 4'h8;
  localparam logic [3:0] OP_TWO_REG_B   = 4'hA;

  // Link between neighboring cells: scan token and best match so far.
  typedef struct packed {
    logic              tok;
    logic              found;
    logic [ADDR_W-1:0] addr;
  } link_t;

  // Slot write broadcast to all cells.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  index;
    logic              enabled;
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] report;
  } wr_t;

  // Accessed range under test, end kept at 65 bits.
  typedef struct packed {
    logic [ADDR_W-1:0] first;
    logic [ADDR_W:0]   lim;
  } probe_t;

  // One result item.
  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] hit_addr;
    logic              is_ls;
    logic [SIZE_W-1:0] size;
  } res_t;

endpackage

// ===== src/whr_if.sv =====
// Handshake channels of the watchpoint hit resolver: input, result, config.
// Depends on nothing; field widths match whr_pkg.
interface whr_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [3:0]  slot_index;
  logic        slot_enabled;
  logic [63:0] slot_watch_addr;
  logic [3:0]  slot_watch_len;
  logic [63:0] slot_report_addr;
  logic [31:0] insn;
  logic [63:0] trap_addr;

  modport source(output valid, action, slot_index, slot_enabled, slot_watch_addr,
                 slot_watch_len, slot_report_addr, insn, trap_addr, input ready);
  modport sink(input valid, action, slot_index, slot_enabled, slot_watch_addr,
               slot_watch_len, slot_report_addr, insn, trap_addr, output ready);
endinterface

interface whr_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [63:0] hit_addr;
  logic        is_load_store;
  logic [6:0]  access_size;

  modport source(output valid, hit, hit_addr, is_load_store, access_size, input ready);
  modport sink(input valid, hit, hit_addr, is_load_store, access_size, output ready);
endinterface

interface whr_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] active_slots;

  modport source(output valid, active_slots, input ready);
  modport sink(input valid, active_slots, output ready);
endinterface

// ===== src/whr_decode.sv =====
// Instruction decoder: load/store class and access size in bytes.
// Depends on whr_pkg for widths and opcode constants.
module whr_decode (
  input  logic [whr_pkg::INSN_W-1:0] insn,
  output logic                       is_ls,
  output logic [whr_pkg::SIZE_W-1:0] size
);

  logic       sve;
  logic [1:0] sz;
  logic [1:0] b2324;
  logic       pair;
  logic       literal;
  logic       vgrp;
  logic       multi;
  logic       single;
  logic       common;
  logic [2:0] code;
  logic [6:0] base;
  logic [3:0] op;

  // Classify the SVE, pair, literal and SIMD structure groups
  always_comb begin
    sve = 1'b0;
    if (insn[28:25] == 4'b0010) begin
      if (insn[31:29] == 3'd4 || insn[31:29] == 3'd5 || insn[31:29] == 3'd6) begin
        sve = 1'b1;
      end else if (insn[31:29] == 3'd7) begin
        sve = !insn[15] || !insn[13] || insn[15:13] == 3'd6 || insn[15:13] == 3'd7;
      end
    end
    sz      = insn[31:30];
    b2324   = insn[24:23];
    pair    = !insn[28] && insn[29];
    literal = insn[28] && !insn[29] && !insn[24];
    vgrp    = insn[29:28] == 2'b00 && !insn[31];
    multi   = vgrp && ((b2324 == 2'd0 && insn[21:16] == 6'd0) ||
                       (b2324 == 2'd1 && !insn[21]));
    single  = vgrp && ((b2324 == 2'd2 && insn[20:16] == 5'd0) || b2324 == 2'd3);
    common  = insn[29:28] == 2'b00 && !insn[26] && b2324 == 2'd0 && insn[11];
    code    = {insn[23], sz};
    base    = insn[30] ? 7'd16 : 7'd8;
    op      = insn[15:12];
    is_ls   = (!insn[25] && insn[27]) || sve;
  end

  // Pick the access size, SVE first, then SIMD, then general registers
  always_comb begin
    size = 7'd0;
    if (!is_ls) begin
      size = 7'd0;
    end else if (sve) begin
      size = whr_pkg::SVE_BYTES;
    end else if (insn[26]) begin
      if (literal) begin
        size = 7'd4 << sz;
      end else if (multi) begin
        if (op == whr_pkg::OP_FOUR_REG_A || op == whr_pkg::OP_FOUR_REG_B) begin
          size = base << 2;
        end else if (op == whr_pkg::OP_THREE_REG_A || op == whr_pkg::OP_THREE_REG_B) begin
          size = base + (base << 1);
        end else if (op == whr_pkg::OP_TWO_REG_A || op == whr_pkg::OP_TWO_REG_B) begin
          size = base << 1;
        end else begin
          size = base;
        end
      end else if (single) begin
        size = base;
      end else if (pair) begin
        size = 7'd8 << sz;
      end else begin
        size = (code == 3'd7) ? 7'd64 : (7'd1 << code);
      end
    end else if (pair) begin
      if (sz == 2'd1) begin
        size = insn[22] ? 7'd8 : 7'd16;
      end else begin
        size = (sz == 2'd0) ? 7'd8 : 7'd16;
      end
    end else if (common && (sz == 2'd0 || insn[31])) begin
      size = base;
    end else if (literal) begin
      size = (sz == 2'd2) ? 7'd4 : (7'd4 << sz);
    end else begin
      size = 7'd1 << sz;
    end
  end

endmodule

// ===== src/whr_cell.sv =====
// One watchpoint slot cell: holds the slot and passes the scan token down.
// Depends on whr_pkg for the link, write and probe structs.
module whr_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  whr_pkg::wr_t                 wr,
  input  logic [whr_pkg::ACTIVE_W-1:0] active_slots,
  input  whr_pkg::probe_t              probe,
  input  whr_pkg::link_t               link_in,
  output whr_pkg::link_t               link_out
);

  logic                        valid_r;
  logic                        len_nz_r;
  logic [whr_pkg::ADDR_W-1:0]  start_r;
  logic [whr_pkg::ADDR_W:0]    lim_r;
  logic [whr_pkg::ADDR_W-1:0]  report_r;
  logic                        tok_r;
  logic                        found_r;
  logic [whr_pkg::ADDR_W-1:0]  addr_r;
  logic                        wr_here;
  logic                        in_scan;
  logic                        overlap;
  logic                        match;

  assign wr_here = wr.en && wr.index == whr_pkg::IDX_W'(CELL_IDX);
  assign in_scan = active_slots > whr_pkg::ACTIVE_W'(CELL_IDX);

  // Slot range nonempty and each range starts before the other ends
  assign overlap = len_nz_r && ({1'b0, probe.first} < lim_r) &&
                   ({1'b0, start_r} < probe.lim);
  assign match   = valid_r && in_scan && overlap;

  // Hold the slot valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_here) begin
      valid_r <= wr.enabled;
    end
  end

  // Store the slot range with its 65-bit end
  always_ff @(posedge clk) begin
    if (wr_here) begin
      start_r  <= wr.start;
      lim_r    <= {1'b0, wr.start} + {{(whr_pkg::ADDR_W + 1 - whr_pkg::LEN_W){1'b0}}, wr.len};
      len_nz_r <= wr.len != '0;
      report_r <= wr.report;
    end
  end

  // Advance the scan token one cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= link_in.tok;
    end
  end

  // Keep the first match from above, else take this slot on a match
  always_ff @(posedge clk) begin
    if (link_in.tok) begin
      found_r <= link_in.found || match;
      addr_r  <= link_in.found ? link_in.addr : report_r;
    end
  end

  assign link_out = '{tok: tok_r, found: found_r, addr: addr_r};

endmodule

// ===== src/watchpoint_hit_resolver.sv =====
// Top level of the watchpoint hit resolver: slot cell chain and handshakes.
// Depends on whr_pkg, whr_if, whr_decode and whr_cell.
//
// The block holds SLOTS watchpoint slots, one per cell in a chain. A write
// item loads one slot and its all-zero result goes through the pending and
// output registers, as does that of a check whose word is not a load/store.
// A load/store check launches a scan token at the highest cell, which walks
// down one cell per clock; its result follows once the token leaves the
// lowest cell. One item is in work at a time: the next item is taken once
// the current result has entered the output register, even if that result
// is still waiting for the sink. Configuration writes are taken in any
// cycle and must only be issued while the block is idle.
module watchpoint_hit_resolver #(
  parameter int SLOTS = whr_pkg::SLOTS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  whr_in_if.sink    in_ch,
  whr_out_if.source out_ch,
  whr_cfg_if.sink   cfg_ch
);

  logic [whr_pkg::ACTIVE_W-1:0] active_slots_r;
  logic                         busy_r;
  logic                         busy_nxt;
  logic                         start_r;
  logic                         start_nxt;
  whr_pkg::probe_t              probe_r;
  logic [whr_pkg::SIZE_W-1:0]   size_r;
  logic                         pend_valid_r;
  logic                         pend_valid_nxt;
  whr_pkg::res_t                pend_res_r;
  whr_pkg::res_t                pend_res_nxt;
  logic                         out_valid_r;
  whr_pkg::res_t                out_res_r;
  logic                         in_acc;
  logic                         out_load;
  logic                         dec_ls;
  logic [whr_pkg::SIZE_W-1:0]   dec_size;
  whr_pkg::wr_t                 wr;
  whr_pkg::link_t               links [SLOTS+1];
  logic [SLOTS-1:0]             tok_vec;

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !busy_r;
  assign cfg_ch.ready = 1'b1;
  assign out_load    = pend_valid_r && (!out_valid_r || out_ch.ready);

  // Register the scan count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_slots_r <= whr_pkg::ACTIVE_RESET;
    end else if (cfg_ch.valid) begin
      active_slots_r <= cfg_ch.active_slots;
    end
  end

  whr_decode u_decode (
    .insn  (in_ch.insn),
    .is_ls (dec_ls),
    .size  (dec_size)
  );

  // Broadcast slot writes to the cells
  assign wr = '{
    en:      in_acc && in_ch.action == whr_pkg::ACT_WRITE,
    index:   in_ch.slot_index,
    enabled: in_ch.slot_enabled,
    start:   in_ch.slot_watch_addr,
    len:     in_ch.slot_watch_len,
    report:  in_ch.slot_report_addr
  };

  // Feed the head of the chain with a fresh token
  assign links[SLOTS] = '{tok: start_r, found: 1'b0, addr: '0};

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    whr_cell #(
      .CELL_IDX (i)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .wr           (wr),
      .active_slots (active_slots_r),
      .probe        (probe_r),
      .link_in      (links[i+1]),
      .link_out     (links[i])
    );
    assign tok_vec[i] = links[i].tok;
  end

  // Sequence one item: launch, collect at the chain end, hand to output
  always_comb begin
    busy_nxt       = busy_r;
    start_nxt      = 1'b0;
    pend_valid_nxt = pend_valid_r;
    pend_res_nxt   = pend_res_r;
    if (out_load) begin
      pend_valid_nxt = 1'b0;
      busy_nxt       = 1'b0;
    end
    if (in_acc) begin
      busy_nxt = 1'b1;
      if (in_ch.action == whr_pkg::ACT_CHECK && dec_ls) begin
        start_nxt = 1'b1;
      end else begin
        pend_valid_nxt = 1'b1;
        pend_res_nxt   = '0;
      end
    end
    if (links[0].tok) begin
      pend_valid_nxt        = 1'b1;
      pend_res_nxt.hit      = links[0].found;
      pend_res_nxt.hit_addr = links[0].found ? links[0].addr : '0;
      pend_res_nxt.is_ls    = 1'b1;
      pend_res_nxt.size     = size_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      start_r      <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      start_r      <= start_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_res_r <= pend_res_nxt;
  end

  // Capture the accessed range of a check
  always_ff @(posedge clk) begin
    if (in_acc) begin
      probe_r.first <= in_ch.trap_addr;
      probe_r.lim   <= {1'b0, in_ch.trap_addr} +
                       {{(whr_pkg::ADDR_W + 1 - whr_pkg::SIZE_W){1'b0}}, dec_size};
      size_r        <= dec_size;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= pend_res_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.hit           = out_res_r.hit;
  assign out_ch.hit_addr      = out_res_r.hit_addr;
  assign out_ch.is_load_store = out_res_r.is_ls;
  assign out_ch.access_size   = out_res_r.size;

  // At most one scan token lives in the chain
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_vec) <= 1)
    else $error("more than one scan token in the cell chain");

  // A token reaching the chain end belongs to the item in work
  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    links[0].tok |-> busy_r && !pend_valid_r)
    else $error("scan result with no check in work");

  // A waiting result keeps the block busy
  a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> busy_r)
    else $error("pending result while idle");

  // Hits come only from load/store checks
  a_hit_ls: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.hit |-> out_res_r.is_ls)
    else $error("hit reported for a non load/store item");

  // Non load/store results are all zero
  a_nols_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.is_ls |-> out_res_r.size == '0 && out_res_r.hit_addr == '0)
    else $error("nonzero fields on a non load/store result");

endmodule
